FILE: rtl/slab_size_class_allocator_assert.svh
// ----------------------------------------------------------------------
// Slab allocator assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_ASSERT_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SCA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCA_ASSERT_NOW(name, ante, cons, msg)
`define SCA_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

FILE: rtl/sca_pkg.sv
// ----------------------------------------------------------------------
// Slab allocator package
// Default geometry, operation and status codes, register map, FSM states.
// ----------------------------------------------------------------------
package sca_pkg;

    localparam int DEF_SLABS_PER_CLASS = 4;
    localparam int DEF_SLAB_SIZE_LOG   = 14;
    localparam int DEF_MIN_CLASS_LOG   = 5;
    localparam int DEF_MAX_CLASS_LOG   = 11;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    // register index, taken from paddr above the 8-byte offset
    localparam logic REG_REGION_BASE = 1'b0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_BIG  = 2'd1,
        STATUS_NO_MEM   = 2'd2,
        STATUS_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/sca_cfg_regs.sv
// ----------------------------------------------------------------------
// Slab allocator configuration registers
// APB-style slave holding the region base address.
// ----------------------------------------------------------------------
module sca_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sca_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sca_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sca_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [63:0]                    region_base
);
    import sca_pkg::*;

    logic [63:0] region_base_reg;
    logic        reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
        end
        else if (wr_en && reg_index == REG_REGION_BASE)
        begin
            region_base_reg <= pwdata;
        end
    end

    assign prdata      = (reg_index == REG_REGION_BASE) ? region_base_reg : '0;
    assign region_base = region_base_reg;

endmodule

FILE: rtl/sca_link_ram.sv
// ----------------------------------------------------------------------
// Slab allocator link memory
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------
module sca_link_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sca_engine.sv
// ----------------------------------------------------------------------
// Slab allocator engine
// Request decode, slab heads and active counts, link RAM sequencing,
// post-reset link initialization and the output stage.
// ----------------------------------------------------------------------
`include "slab_size_class_allocator_assert.svh"

module sca_engine #(
    parameter int SLABS_PER_CLASS = sca_pkg::DEF_SLABS_PER_CLASS,
    parameter int SLAB_SIZE_LOG   = sca_pkg::DEF_SLAB_SIZE_LOG,
    parameter int MIN_CLASS_LOG   = sca_pkg::DEF_MIN_CLASS_LOG,
    parameter int MAX_CLASS_LOG   = sca_pkg::DEF_MAX_CLASS_LOG,
    parameter int LINK_DEPTH      = 16,
    parameter int LA_W            = 4,
    parameter int SLOT_BITS       = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [63:0]          region_base,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [15:0]          request_size,
    input  logic [63:0]          free_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          object_address,
    output logic [3:0]           size_class,
    output logic [1:0]           status,
    output logic                 link_we,
    output logic [LA_W-1:0]      link_waddr,
    output logic [SLOT_BITS-1:0] link_wdata,
    output logic                 link_re,
    output logic [LA_W-1:0]      link_raddr,
    input  logic [SLOT_BITS-1:0] link_rdata
);
    import sca_pkg::*;

    localparam int NUM_CLASSES = MAX_CLASS_LOG - MIN_CLASS_LOG + 1;
    localparam int NUM_SLABS   = NUM_CLASSES * SLABS_PER_CLASS;
    localparam int CI_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int S_W         = (SLABS_PER_CLASS > 1) ? $clog2(SLABS_PER_CLASS) : 1;
    localparam int A_W         = $clog2(SLABS_PER_CLASS + 1);
    localparam int G_W         = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int GH_W        = 64 - SLAB_SIZE_LOG;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [CI_W-1:0] class_of(input logic [G_W-1:0] g);
        logic [CI_W-1:0] r;
        r = '0;
        for (int k = 1; k < NUM_CLASSES; k++)
        begin
            if (int'(g) >= k * SLABS_PER_CLASS)
            begin
                r = CI_W'(k);
            end
        end
        return r;
    endfunction

    // highest slot index of a slab in this class, zero when it holds none
    function automatic logic [SLOT_BITS-1:0] last_slot(input logic [CI_W-1:0] ci);
        return {SLOT_BITS{1'b1}} >> ci;
    endfunction

    function automatic logic [LA_W-1:0] link_addr(input logic [G_W-1:0] g,
                                                  input logic [SLOT_BITS-1:0] slot);
        return LA_W'({g, slot});
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic                  out_valid_reg;
    logic [63:0]           out_addr_reg;
    logic [3:0]            out_cls_reg;
    status_t               out_status_reg;
    logic [63:0]           res_addr_reg;
    logic [3:0]            res_cls_reg;
    status_t               res_status_reg;
    logic [G_W-1:0]        pop_g_reg;
    logic [SLOT_BITS-1:0]  pop_slot_reg;
    logic [CI_W-1:0]       pop_ci_reg;
    logic [S_W-1:0]        pop_s_reg;
    logic [LA_W-1:0]       clr_addr_reg;
    logic [SLOT_BITS-1:0]  head_reg   [NUM_CLASSES][SLABS_PER_CLASS];
    logic [A_W-1:0]        active_reg [NUM_CLASSES];

    // ------------------------------------------------------------------
    // allocate decode
    // ------------------------------------------------------------------
    logic                  too_big;
    logic [CI_W-1:0]       ci_a;
    logic [A_W-1:0]        act;
    logic [SLOT_BITS-1:0]  row [SLABS_PER_CLASS];
    logic                  hit;
    logic [S_W-1:0]        hit_s;
    logic                  grow;
    logic [S_W-1:0]        grow_s;
    logic                  pop_ok;
    logic [S_W-1:0]        pop_s;
    logic [SLOT_BITS-1:0]  pop_slot;
    logic [G_W-1:0]        alloc_g;

    always_comb
    begin
        too_big = {1'b0, request_size} > (17'd1 << MAX_CLASS_LOG);
        ci_a    = '0;
        for (int k = 0; k < NUM_CLASSES - 1; k++)
        begin
            if ({1'b0, request_size} > (17'd1 << (MIN_CLASS_LOG + k)))
            begin
                ci_a = CI_W'(k + 1);
            end
        end
        act = active_reg[ci_a];
        row = head_reg[ci_a];
        // newest active slab with a free slot wins
        hit   = 1'b0;
        hit_s = '0;
        for (int s = 0; s < SLABS_PER_CLASS; s++)
        begin
            if (A_W'(s) < act && row[s] != '0)
            begin
                hit   = 1'b1;
                hit_s = S_W'(s);
            end
        end
        grow     = !hit && (act < A_W'(SLABS_PER_CLASS));
        grow_s   = S_W'(act);
        pop_ok   = hit || (grow && row[grow_s] != '0);
        pop_s    = hit ? hit_s : grow_s;
        pop_slot = row[pop_s];
        alloc_g  = G_W'(int'(ci_a) * SLABS_PER_CLASS + int'(pop_s));
    end

    // ------------------------------------------------------------------
    // free decode
    // ------------------------------------------------------------------
    logic [63:0]              off;
    logic [GH_W-1:0]          gh;
    logic                     in_range;
    logic [G_W-1:0]           gf;
    logic [CI_W-1:0]          ci_f;
    logic [S_W-1:0]           sf;
    logic [3:0]               c_f;
    logic [SLAB_SIZE_LOG-1:0] slab_off;
    logic [SLAB_SIZE_LOG-1:0] align_mask;
    logic [SLOT_BITS-1:0]     slot_f;
    logic                     free_ok;

    always_comb
    begin
        off        = free_address - region_base;
        gh         = off[63:SLAB_SIZE_LOG];
        in_range   = gh < GH_W'(NUM_SLABS);
        gf         = G_W'(gh);
        ci_f       = class_of(gf);
        sf         = S_W'(gf - G_W'(int'(ci_f) * SLABS_PER_CLASS));
        c_f        = 4'(MIN_CLASS_LOG + int'(ci_f));
        slab_off   = off[SLAB_SIZE_LOG-1:0];
        // a class at or above the slab size masks everything
        align_mask = ~({SLAB_SIZE_LOG{1'b1}} << c_f);
        slot_f     = SLOT_BITS'(slab_off >> c_f);
        free_ok    = in_range && (A_W'(sf) < active_reg[ci_f])
                     && ((slab_off & align_mask) == '0) && (slot_f != '0);
    end

    // ------------------------------------------------------------------
    // accepted beat classification and immediate result
    // ------------------------------------------------------------------
    logic    accept;
    logic    acc_alloc;
    logic    acc_free;
    logic    alloc_take;
    logic    grow_take;
    logic    free_take;
    logic    out_free;
    logic [3:0] acc_cls;
    status_t acc_status;

    assign accept     = in_valid && in_ready;
    assign acc_alloc  = accept && (func == FUNC_ALLOC);
    assign acc_free   = accept && (func == FUNC_FREE);
    assign alloc_take = acc_alloc && !too_big && pop_ok;
    assign grow_take  = acc_alloc && !too_big && grow;
    assign free_take  = acc_free && free_ok;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        acc_cls    = 4'(MIN_CLASS_LOG);
        acc_status = STATUS_OK;
        if (func == FUNC_ALLOC)
        begin
            if (too_big)
            begin
                acc_status = STATUS_TOO_BIG;
            end
            else
            begin
                acc_cls    = 4'(MIN_CLASS_LOG + int'(ci_a));
                acc_status = pop_ok ? STATUS_OK : STATUS_NO_MEM;
            end
        end
        else if (free_ok)
        begin
            acc_cls = c_f;
        end
        else
        begin
            acc_status = STATUS_BAD_FREE;
        end
    end

    // slots never overlap the slab number bits, so one add forms the address
    logic [63:0] pop_addr;
    assign pop_addr = region_base
                      + ((64'(pop_g_reg) << SLAB_SIZE_LOG) | (64'(pop_slot_reg) << res_cls_reg));

    // ------------------------------------------------------------------
    // post-reset link initialization
    // ------------------------------------------------------------------
    logic [G_W-1:0]       clr_g;
    logic [SLOT_BITS-1:0] clr_slot;
    logic [SLOT_BITS-1:0] clr_last;
    logic [SLOT_BITS-1:0] clr_wdata;
    logic                 clr_done;

    assign clr_g     = G_W'(clr_addr_reg >> SLOT_BITS);
    assign clr_slot  = clr_addr_reg[SLOT_BITS-1:0];
    assign clr_last  = last_slot(class_of(clr_g));
    assign clr_wdata = (clr_slot < clr_last) ? clr_slot + 1'b1 : '0;
    assign clr_done  = clr_addr_reg == LA_W'(LINK_DEPTH - 1);

    // ------------------------------------------------------------------
    // link RAM ports
    // ------------------------------------------------------------------
    assign link_we    = (state_reg == ST_CLEAR) || free_take;
    assign link_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : link_addr(gf, slot_f);
    assign link_wdata = (state_reg == ST_CLEAR) ? clr_wdata : head_reg[ci_f][sf];
    assign link_re    = alloc_take;
    assign link_raddr = link_addr(alloc_g, pop_slot);

    // ------------------------------------------------------------------
    // control FSM
    // ------------------------------------------------------------------
    logic        out_load;
    logic        res_load_acc;
    logic        res_load_pop;
    logic [63:0] emit_addr;
    logic [3:0]  emit_cls;
    status_t     emit_status;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_load     = 1'b0;
        res_load_acc = 1'b0;
        res_load_pop = 1'b0;
        emit_addr    = res_addr_reg;
        emit_cls     = res_cls_reg;
        emit_status  = res_status_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                emit_addr   = '0;
                emit_cls    = acc_cls;
                emit_status = acc_status;
                if (in_valid)
                begin
                    if (alloc_take)
                    begin
                        res_load_acc = 1'b1;
                        state_next   = ST_POP;
                    end
                    else if (out_free)
                    begin
                        out_load = 1'b1;
                    end
                    else
                    begin
                        res_load_acc = 1'b1;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_POP:
            begin
                emit_addr = pop_addr;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    res_load_pop = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // slab heads and active slab counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                active_reg[c] <= A_W'(1);
                for (int s = 0; s < SLABS_PER_CLASS; s++)
                begin
                    head_reg[c][s] <= (last_slot(CI_W'(c)) != '0)
                                      ? SLOT_BITS'(1) : '0;
                end
            end
        end
        else
        begin
            if (grow_take)
            begin
                active_reg[ci_a] <= act + 1'b1;
            end
            if (free_take)
            begin
                head_reg[ci_f][sf] <= slot_f;
            end
            if (state_reg == ST_POP)
            begin
                head_reg[pop_ci_reg][pop_s_reg] <= link_rdata;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (alloc_take)
        begin
            pop_g_reg    <= alloc_g;
            pop_slot_reg <= pop_slot;
            pop_ci_reg   <= ci_a;
            pop_s_reg    <= pop_s;
        end
        if (res_load_acc)
        begin
            res_addr_reg   <= '0;
            res_cls_reg    <= acc_cls;
            res_status_reg <= acc_status;
        end
        else if (res_load_pop)
        begin
            res_addr_reg <= pop_addr;
        end
        if (out_load)
        begin
            out_addr_reg   <= emit_addr;
            out_cls_reg    <= emit_cls;
            out_status_reg <= emit_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign object_address = out_addr_reg;
    assign size_class     = out_cls_reg;
    assign status         = out_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SCA_ASSERT_NOW(a_emit_has_stalled_beat, state_reg == ST_EMIT, out_valid_reg, "emit wait with empty output stage")
    `SCA_ASSERT_NOW(a_link_single_access, link_re, !link_we, "link read and write in one cycle")
    `SCA_ASSERT_NEXT(a_pop_follows_hit, alloc_take, state_reg == ST_POP && !in_ready, "slab pop did not follow an allocate hit")
    `SCA_ASSERT_NOW(a_no_output_in_clear, state_reg == ST_CLEAR, !out_valid_reg && !link_re, "activity during link initialization")

endmodule

FILE: rtl/slab_size_class_allocator.sv
// ----------------------------------------------------------------------
// Slab size class allocator
// Power-of-two slab allocator over a fixed region: top level.
// ----------------------------------------------------------------------
// After reset the block walks the link RAM once to build every slab's
// free list, one entry per cycle over NUM_SLABS * 2^(SLAB_SIZE_LOG -
// MIN_CLASS_LOG) entries (14336 with the defaults), during which in_ready
// stays low; configuration writes are taken throughout. One request is
// in flight at a time. A free, a failed allocate and an oversize request
// are resolved as they are accepted; an allocate that pops a slot goes
// through ST_POP, as the slab's next head comes from the link RAM's
// registered read. The result lands in the output register at the end
// of that work and the block takes the next beat while it waits there.
module slab_size_class_allocator #(
    parameter int SLABS_PER_CLASS = sca_pkg::DEF_SLABS_PER_CLASS,
    parameter int SLAB_SIZE_LOG   = sca_pkg::DEF_SLAB_SIZE_LOG,
    parameter int MIN_CLASS_LOG   = sca_pkg::DEF_MIN_CLASS_LOG,
    parameter int MAX_CLASS_LOG   = sca_pkg::DEF_MAX_CLASS_LOG
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sca_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sca_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sca_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [15:0]                    request_size,
    input  logic [63:0]                    free_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [63:0]                    object_address,
    output logic [3:0]                     size_class,
    output logic [1:0]                     status
);
    import sca_pkg::*;

    localparam int NUM_CLASSES = MAX_CLASS_LOG - MIN_CLASS_LOG + 1;
    localparam int NUM_SLABS   = NUM_CLASSES * SLABS_PER_CLASS;
    localparam int SLOT_BITS   = SLAB_SIZE_LOG - MIN_CLASS_LOG;
    localparam int LINK_DEPTH  = NUM_SLABS << SLOT_BITS;
    localparam int LA_W        = $clog2(LINK_DEPTH);

    logic [63:0]          region_base;
    logic                 link_we;
    logic [LA_W-1:0]      link_waddr;
    logic [SLOT_BITS-1:0] link_wdata;
    logic                 link_re;
    logic [LA_W-1:0]      link_raddr;
    logic [SLOT_BITS-1:0] link_rdata;

    sca_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .region_base (region_base)
    );

    sca_link_ram #(
        .DEPTH (LINK_DEPTH),
        .AW    (LA_W),
        .DW    (SLOT_BITS)
    ) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    sca_engine #(
        .SLABS_PER_CLASS (SLABS_PER_CLASS),
        .SLAB_SIZE_LOG   (SLAB_SIZE_LOG),
        .MIN_CLASS_LOG   (MIN_CLASS_LOG),
        .MAX_CLASS_LOG   (MAX_CLASS_LOG),
        .LINK_DEPTH      (LINK_DEPTH),
        .LA_W            (LA_W),
        .SLOT_BITS       (SLOT_BITS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .region_base    (region_base),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .request_size   (request_size),
        .free_address   (free_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .object_address (object_address),
        .size_class     (size_class),
        .status         (status),
        .link_we        (link_we),
        .link_waddr     (link_waddr),
        .link_wdata     (link_wdata),
        .link_re        (link_re),
        .link_raddr     (link_raddr),
        .link_rdata     (link_rdata)
    );

endmodule

FILE: tb/sca_alloc_checker.sv
// ----------------------------------------------------------------------
// Slab allocator result checker
// Follows every accepted request and config write, keeps a shadow of the
// free lists, the active slab counts and the region base, and compares
// each result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------
module sca_alloc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [sca_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sca_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           func,
    input  logic [15:0]                    request_size,
    input  logic [63:0]                    free_address,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [63:0]                    object_address,
    input  logic [3:0]                     size_class,
    input  logic [1:0]                     status,
    output int                             fail_count,
    output int                             pending
);
    import sca_pkg::*;

    localparam int SLABS       = DEF_SLABS_PER_CLASS;
    localparam int SLAB_LOG    = DEF_SLAB_SIZE_LOG;
    localparam int MIN_LOG     = DEF_MIN_CLASS_LOG;
    localparam int MAX_LOG     = DEF_MAX_CLASS_LOG;
    localparam int NUM_CLASSES = MAX_LOG - MIN_LOG + 1;
    localparam int NUM_SLABS   = NUM_CLASSES * SLABS;
    localparam int SLOT_BITS   = SLAB_LOG - MIN_LOG;
    localparam int LINK_DEPTH  = NUM_SLABS << SLOT_BITS;

    typedef struct packed {
        logic [63:0] addr;
        logic [3:0]  cls;
        status_t     st;
    } alloc_result_t;

    logic [SLOT_BITS-1:0] link_ram [LINK_DEPTH];
    logic [SLOT_BITS-1:0] free_head [NUM_SLABS];
    int                   active_count [NUM_CLASSES];
    logic [63:0]          base;
    alloc_result_t        expected_results [$];
    alloc_result_t        exp_r;
    int                   errs;

    function automatic int last_slot(input int c);
        return (1 << (SLAB_LOG - c)) - 1;
    endfunction

    function automatic void rebuild_free_lists();
        int last;
        for (int i = 0; i < LINK_DEPTH; i++)
            link_ram[i] = '0;
        for (int g = 0; g < NUM_SLABS; g++)
        begin
            last = last_slot(MIN_LOG + g / SLABS);
            free_head[g] = SLOT_BITS'((last >= 1) ? 1 : 0);
            for (int i = 1; i <= last; i++)
                link_ram[(g << SLOT_BITS) + i] = SLOT_BITS'((i < last) ? i + 1 : 0);
        end
        for (int k = 0; k < NUM_CLASSES; k++)
            active_count[k] = 1;
    endfunction

    function automatic logic [63:0] pop_slot(input int g, input int c);
        int slot;
        slot = int'(free_head[g]);
        free_head[g] = link_ram[(g << SLOT_BITS) + slot];
        return base + (64'(g) << SLAB_LOG) + (64'(slot) << c);
    endfunction

    function automatic alloc_result_t predict_op(input logic op, input logic [15:0] sz,
                                                 input logic [63:0] fa);
        alloc_result_t r;
        int            c, ci, g, s, act, slot;
        logic          found;
        logic [63:0]   off, slab_off;
        r.addr = '0;
        r.cls  = 4'(MIN_LOG);
        r.st   = STATUS_OK;
        if (op == FUNC_ALLOC)
        begin
            if (sz > (1 << MAX_LOG))
                r.st = STATUS_TOO_BIG;
            else
            begin
                c = MIN_LOG;
                while ((1 << c) < sz)
                    c++;
                ci = c - MIN_LOG;
                act = active_count[ci];
                found = 1'b0;
                // newest active slab first
                for (s = act; s >= 1; s--)
                begin
                    if (!found && free_head[ci * SLABS + s - 1] != 0)
                    begin
                        r.addr = pop_slot(ci * SLABS + s - 1, c);
                        found = 1'b1;
                    end
                end
                if (!found && act < SLABS)
                begin
                    g = ci * SLABS + act;
                    active_count[ci] = act + 1;
                    if (free_head[g] != 0)
                    begin
                        r.addr = pop_slot(g, c);
                        found = 1'b1;
                    end
                end
                if (!found)
                    r.st = STATUS_NO_MEM;
                r.cls = 4'(c);
            end
        end
        else
        begin
            r.st = STATUS_BAD_FREE;
            off = fa - base;
            if ((off >> SLAB_LOG) < 64'(NUM_SLABS))
            begin
                g = int'(off >> SLAB_LOG);
                ci = g / SLABS;
                c = MIN_LOG + ci;
                slab_off = off & ((64'd1 << SLAB_LOG) - 1);
                slot = int'(slab_off >> c);
                if (g % SLABS < active_count[ci] && (slab_off & ((64'd1 << c) - 1)) == 0
                    && slot >= 1 && slot <= last_slot(c))
                begin
                    link_ram[(g << SLOT_BITS) + slot] = free_head[g];
                    free_head[g] = SLOT_BITS'(slot);
                    r.st = STATUS_OK;
                    r.cls = 4'(c);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rebuild_free_lists();
            base = '0;
            expected_results.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pwrite && pready && paddr[3] == REG_REGION_BASE)
                base = pwdata;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: object_address %h", object_address);
                    errs++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (object_address !== exp_r.addr)
                    begin
                        $error("object_address: expected %h, got %h", exp_r.addr, object_address);
                        errs++;
                    end
                    if (size_class !== exp_r.cls)
                    begin
                        $error("size_class: expected %0d, got %0d", exp_r.cls, size_class);
                        errs++;
                    end
                    if (status !== exp_r.st)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.st, status);
                        errs++;
                    end
                end
            end
            // a request cannot produce its result in the beat it is taken
            if (in_valid && in_ready)
                expected_results.push_back(predict_op(func, request_size, free_address));
            fail_count <= fail_count + errs;
            pending <= expected_results.size();
        end
    end

endmodule

FILE: tb/slab_size_class_allocator_test.sv
// ----------------------------------------------------------------------
// Slab allocator testbench
// Drives directed and random allocate/free traffic through several region
// base settings and backpressure mixes; the checker scores every result.
// ----------------------------------------------------------------------
module slab_size_class_allocator_test;
    import sca_pkg::*;

    localparam int SLABS       = DEF_SLABS_PER_CLASS;
    localparam int SLAB_LOG    = DEF_SLAB_SIZE_LOG;
    localparam int MIN_LOG     = DEF_MIN_CLASS_LOG;
    localparam int MAX_LOG     = DEF_MAX_CLASS_LOG;
    localparam int NUM_SLABS   = (MAX_LOG - MIN_LOG + 1) * SLABS;
    // covers the link RAM clearing pass after reset with room to spare
    localparam int STALL_LIMIT = 50000;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  func         = FUNC_ALLOC;
    logic [15:0]           request_size = '0;
    logic [63:0]           free_address = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [63:0]           object_address;
    logic [3:0]            size_class;
    logic [1:0]            status;

    int          fail_count;
    int          pending;
    int          stall_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    logic [63:0] region_base_cur = '0;
    logic        sent_funcs [$];
    logic [63:0] live_offsets [$];

    slab_size_class_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .request_size   (request_size),
        .free_address   (free_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .object_address (object_address),
        .size_class     (size_class),
        .status         (status)
    );

    sca_alloc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .request_size   (request_size),
        .free_address   (free_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .object_address (object_address),
        .size_class     (size_class),
        .status         (status),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // track live objects as offsets into the region so they survive base changes
    always @(posedge clk)
    begin
        if (out_valid && out_ready && sent_funcs.size() != 0)
        begin
            if (sent_funcs[0] == FUNC_ALLOC && status == STATUS_OK)
                live_offsets.push_back(object_address - region_base_cur);
            sent_funcs.delete(0);
        end
        if (in_valid && in_ready)
            sent_funcs.push_back(func);
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] slab_addr(input int g, input int slot, input int c);
        return region_base_cur + (64'(g) << SLAB_LOG) + (64'(slot) << c);
    endfunction

    function automatic logic [15:0] size_for_class(input int c);
        if (c == MIN_LOG)
            return 16'($urandom_range(0, 1 << MIN_LOG));
        return 16'($urandom_range((1 << (c - 1)) + 1, 1 << c));
    endfunction

    // hits slot 0, inactive slabs, misalignment, addresses past the region
    function automatic logic [63:0] crafted_free_addr();
        int          g, c;
        logic [63:0] a;
        g = $urandom_range(0, NUM_SLABS + 3);
        c = (g < NUM_SLABS) ? MIN_LOG + g / SLABS : MIN_LOG;
        a = slab_addr(g, $urandom_range(0, (1 << (SLAB_LOG - c)) - 1), c);
        if ($urandom_range(3) == 0)
            a += 64'($urandom_range(1, (1 << c) - 1));
        return a;
    endfunction

    task automatic send_op(input logic op, input logic [15:0] sz, input logic [63:0] fa);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        request_size <= sz;
        free_address <= fa;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic alloc_op(input logic [15:0] sz);
        send_op(FUNC_ALLOC, sz, rand64());
    endtask

    task automatic free_op(input logic [63:0] fa);
        send_op(FUNC_FREE, 16'($urandom), fa);
    endtask

    task automatic write_region_base(input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_REGION_BASE, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        region_base_cur = value;
    endtask

    // hold off new beats until every outstanding result is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(input int n);
        int          left, pick, len, idx, c;
        logic [63:0] fa;
        left = n;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                c = $urandom_range(MIN_LOG, MAX_LOG);
                len = $urandom_range(1, 10);
                repeat (len) alloc_op(size_for_class(c));
                left -= len;
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    if (live_offsets.size() == 0)
                        free_op(crafted_free_addr());
                    else
                    begin
                        idx = $urandom_range(0, live_offsets.size() - 1);
                        fa = region_base_cur + live_offsets[idx];
                        // now and then keep it so the object gets freed twice
                        if ($urandom_range(19) != 0)
                            live_offsets.delete(idx);
                        free_op(fa);
                    end
                end
                left -= len;
            end
            else
            begin
                case ($urandom_range(3))
                    0: alloc_op(16'($urandom_range((1 << MAX_LOG) + 1, 65535)));
                    1: alloc_op(16'($urandom));
                    2: free_op(rand64());
                    default: free_op(crafted_free_addr());
                endcase
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        write_region_base(64'd0);

        send_idle_pct = 28;
        recv_idle_pct = 68;
        alloc_op(16'd0);
        alloc_op(16'd1);
        alloc_op(16'd32);
        alloc_op(16'd33);
        alloc_op(16'd64);
        alloc_op(16'd65);
        alloc_op(16'd256);
        alloc_op(16'd512);
        alloc_op(16'd1000);
        alloc_op(16'd2048);
        alloc_op(16'd2049);
        alloc_op(16'hFFFF);
        free_op(slab_addr(0, 1, MIN_LOG));
        free_op(slab_addr(0, 1, MIN_LOG));      // double free, not caught
        alloc_op(16'd16);
        alloc_op(16'd16);
        free_op(slab_addr(0, 0, MIN_LOG));      // reserved slot
        free_op(slab_addr(0, 1, MIN_LOG) + 1);  // misaligned
        free_op(slab_addr(1, 1, MIN_LOG));      // slab not yet active
        free_op(slab_addr(NUM_SLABS, 1, MIN_LOG));
        free_op('1);
        free_op(slab_addr(NUM_SLABS - SLABS, (1 << (SLAB_LOG - MAX_LOG)) - 1, MAX_LOG));
        alloc_op(16'd2048);
        run_random(200);
        drain();

        write_region_base(64'hFFFF_FFFF_FFFF_C000);
        send_idle_pct = 68;
        recv_idle_pct = 28;
        run_random(200);
        drain();

        write_region_base(rand64());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(120);
        drain();

        write_region_base('1);
        run_random(40);
        drain();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
